// ===== hdl/seecs_pkg.sv =====
`default_nettype none

package seecs_pkg;

    // Sequencer phases.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_POLL1  = 3'd1,
        PH_POLL2  = 3'd2,
        PH_WREN   = 3'd3,
        PH_WFRAME = 3'd4,
        PH_RFRAME = 3'd5
    } t_phase;

    // Request opcodes.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RX    = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SPI  = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // EEPROM instruction bytes.
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [8:0] address;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic       frame_end;
        logic [7:0] read_data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]          cnt;
        t_result [MAX_RESULTS-1:0] res;
    } t_batch;

    function automatic t_result mk_spi(input logic [7:0] tx, input logic fend,
                                       input logic last);
        t_result r;
        r.kind      = KIND_SPI;
        r.tx_byte   = tx;
        r.frame_end = fend;
        r.read_data = 8'h00;
        r.last      = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/seecs_seq.sv =====
`default_nettype none

// Command sequencer: holds the protocol state and turns one item into a
// batch of up to three results.
module seecs_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  seecs_pkg::t_item    i_item,
    input  wire                 i_commit,
    output seecs_pkg::t_batch   o_batch
);

    seecs_pkg::t_phase r_phase, n_phase;
    logic [1:0] r_rx_count, n_rx_count;
    logic [8:0] r_held_address, n_held_address;
    logic [7:0] r_held_data, n_held_data;
    logic       r_is_write, n_is_write;

    logic [1:0] w_rx_inc;
    logic       w_pair_done;
    logic       w_triple_done;
    logic       w_wip;
    logic       w_is_req;
    logic [7:0] w_a8_bit;

    assign w_rx_inc      = r_rx_count + 2'd1;
    assign w_pair_done   = w_rx_inc[1];
    assign w_triple_done = (w_rx_inc == 2'd3);
    assign w_wip         = i_item.rx_byte[0];
    assign w_is_req      = (i_item.opcode == seecs_pkg::OP_READ) ||
                           (i_item.opcode == seecs_pkg::OP_WRITE);
    assign w_a8_bit      = {4'b0000, r_held_address[8], 3'b000};

    // Next state.
    always_comb begin
        n_phase        = r_phase;
        n_rx_count     = r_rx_count;
        n_held_address = r_held_address;
        n_held_data    = r_held_data;
        n_is_write     = r_is_write;
        if (w_is_req) begin
            if (r_phase == seecs_pkg::PH_IDLE) begin
                n_held_address = i_item.address;
                n_held_data    = i_item.write_data;
                n_is_write     = i_item.opcode[0];
                n_rx_count     = 2'd0;
                n_phase        = seecs_pkg::PH_POLL1;
            end
        end else if (i_item.opcode == seecs_pkg::OP_RX) begin
            if (r_phase != seecs_pkg::PH_IDLE) begin
                n_rx_count = w_rx_inc;
                case (r_phase)
                    seecs_pkg::PH_POLL1, seecs_pkg::PH_POLL2: begin
                        if (w_pair_done) begin
                            n_rx_count = 2'd0;
                            if (!w_wip) begin
                                if (r_phase == seecs_pkg::PH_POLL1 && r_is_write) begin
                                    n_phase = seecs_pkg::PH_POLL2;
                                end else if (r_phase == seecs_pkg::PH_POLL1) begin
                                    n_phase = seecs_pkg::PH_RFRAME;
                                end else begin
                                    n_phase = seecs_pkg::PH_WREN;
                                end
                            end
                        end
                    end
                    seecs_pkg::PH_WREN: begin
                        n_rx_count = 2'd0;
                        n_phase    = seecs_pkg::PH_WFRAME;
                    end
                    seecs_pkg::PH_WFRAME, seecs_pkg::PH_RFRAME: begin
                        if (w_triple_done) begin
                            n_rx_count = 2'd0;
                            n_phase    = seecs_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        n_rx_count = 2'd0;
                        n_phase    = seecs_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Results.
    always_comb begin
        o_batch = '0;
        if (w_is_req) begin
            if (r_phase == seecs_pkg::PH_IDLE) begin
                o_batch.cnt    = 2'd2;
                o_batch.res[0] = seecs_pkg::mk_spi(seecs_pkg::CMD_RDSR, 1'b0, 1'b0);
                o_batch.res[1] = seecs_pkg::mk_spi(8'h00, 1'b1, 1'b1);
            end
        end else if (i_item.opcode == seecs_pkg::OP_RX) begin
            case (r_phase)
                seecs_pkg::PH_POLL1, seecs_pkg::PH_POLL2: begin
                    if (w_pair_done) begin
                        if (w_wip || (r_phase == seecs_pkg::PH_POLL1 && r_is_write)) begin
                            o_batch.cnt    = 2'd2;
                            o_batch.res[0] = seecs_pkg::mk_spi(seecs_pkg::CMD_RDSR,
                                                               1'b0, 1'b0);
                            o_batch.res[1] = seecs_pkg::mk_spi(8'h00, 1'b1, 1'b1);
                        end else if (r_phase == seecs_pkg::PH_POLL1) begin
                            o_batch.cnt    = 2'd3;
                            o_batch.res[0] = seecs_pkg::mk_spi(
                                seecs_pkg::CMD_READ | w_a8_bit, 1'b0, 1'b0);
                            o_batch.res[1] = seecs_pkg::mk_spi(r_held_address[7:0],
                                                               1'b0, 1'b0);
                            o_batch.res[2] = seecs_pkg::mk_spi(8'h00, 1'b1, 1'b1);
                        end else begin
                            o_batch.cnt    = 2'd1;
                            o_batch.res[0] = seecs_pkg::mk_spi(seecs_pkg::CMD_WREN,
                                                               1'b1, 1'b1);
                        end
                    end
                end
                seecs_pkg::PH_WREN: begin
                    o_batch.cnt    = 2'd3;
                    o_batch.res[0] = seecs_pkg::mk_spi(
                        seecs_pkg::CMD_WRITE | w_a8_bit, 1'b0, 1'b0);
                    o_batch.res[1] = seecs_pkg::mk_spi(r_held_address[7:0], 1'b0, 1'b0);
                    o_batch.res[2] = seecs_pkg::mk_spi(r_held_data, 1'b1, 1'b1);
                end
                seecs_pkg::PH_WFRAME: begin
                    if (w_triple_done) begin
                        o_batch.cnt         = 2'd1;
                        o_batch.res[0].kind = seecs_pkg::KIND_DONE;
                        o_batch.res[0].last = 1'b1;
                    end
                end
                seecs_pkg::PH_RFRAME: begin
                    if (w_triple_done) begin
                        o_batch.cnt              = 2'd1;
                        o_batch.res[0].kind      = seecs_pkg::KIND_READ;
                        o_batch.res[0].read_data = i_item.rx_byte;
                        o_batch.res[0].last      = 1'b1;
                    end
                end
                default: begin
                    o_batch = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= seecs_pkg::PH_IDLE;
            r_rx_count     <= 2'd0;
            r_held_address <= 9'd0;
            r_held_data    <= 8'd0;
            r_is_write     <= 1'b0;
        end else if (i_commit) begin
            r_phase        <= n_phase;
            r_rx_count     <= n_rx_count;
            r_held_address <= n_held_address;
            r_held_data    <= n_held_data;
            r_is_write     <= n_is_write;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/seecs_rbuf.sv =====
`default_nettype none

// Result buffer: takes a batch of up to three results at once and hands
// them out one per cycle while i_ready is high, shifting toward entry zero.
module seecs_rbuf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  seecs_pkg::t_batch   i_batch,
    input  wire                 i_ready,
    output logic                o_valid,
    output seecs_pkg::t_result  o_res,
    output logic                o_free
);

    seecs_pkg::t_result [seecs_pkg::MAX_RESULTS-1:0] r_ent;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_ent[0];
    assign w_pop   = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_batch.cnt;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_batch.res;
        end else if (w_pop) begin
            r_ent[0] <= r_ent[1];
            r_ent[1] <= r_ent[2];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/spi_eeprom_command_sequencer_core.sv =====
// Path: an accepted request waits in the input register, the sequencer decides
// it combinationally; its results reach the master side via the result buffer.
// Throughput: one request per cycle when it causes no result, or one result and
// m_axis_tready is high; one causing n results holds the buffer until all drain.
// Reset: i_rst_n is synchronous, active low; it returns the sequencer to idle.
`default_nettype none

module spi_eeprom_command_sequencer_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Slave side: host requests and received SPI bytes.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, from bit 0: address[8:0], write_data[7:0], rx_byte[7:0], zero fill
    input  wire  [seecs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  wire  [1:0]  s_axis_tuser,
    // Master side: SPI bytes to send and host responses.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata, from bit 0: tx_byte[7:0], frame_end, read_data[7:0], zero fill
    output logic [seecs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]  m_axis_tuser,
    // tlast: last result caused by one request
    output logic        m_axis_tlast
);

    // The design has these working parts. An input register holds one request;
    // the sequencer turns that request and its protocol state into a batch of
    // up to three results combinationally. The batch lands in the result buffer,
    // which shifts them out one per cycle while m_axis_tready is high. A held
    // request moves on when it makes no results or the buffer empties at this edge.

    logic                r_in_valid;
    seecs_pkg::t_item    r_item;
    seecs_pkg::t_batch   w_batch;
    seecs_pkg::t_result  w_res;
    logic                w_buf_free;
    logic                w_advance;
    logic                w_load;
    logic                w_in_take;

    assign w_advance     = r_in_valid && ((w_batch.cnt == 2'd0) || w_buf_free);
    assign w_load        = w_advance && (w_batch.cnt != 2'd0);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // The request register carries payload only, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_item.opcode     <= s_axis_tuser;
            r_item.address    <= s_axis_tdata[8:0];
            r_item.write_data <= s_axis_tdata[16:9];
            r_item.rx_byte    <= s_axis_tdata[24:17];
        end
    end

    seecs_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_item),
        .i_commit (w_advance),
        .o_batch  (w_batch)
    );

    seecs_rbuf u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_batch  (w_batch),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_res    (w_res),
        .o_free   (w_buf_free)
    );

    assign m_axis_tdata = {7'b0000000, w_res.read_data, w_res.frame_end, w_res.tx_byte};
    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;

    // A held request is never dropped without being processed.
    a_hold_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> r_in_valid)
        else $error("held request lost without being processed");

    // Host responses are always the single, final result of their request.
    a_host_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != seecs_pkg::KIND_SPI) |-> m_axis_tlast)
        else $error("host response not marked last");

    // Read data is zero on every result that is not a read response.
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != seecs_pkg::KIND_READ)
            |-> (m_axis_tdata[16:9] == 8'h00))
        else $error("read data set on a non-read result");

    // Chip deselect only accompanies a transmitted byte.
    a_fend_spi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tuser == seecs_pkg::KIND_SPI))
        else $error("frame end on a non-SPI result");

endmodule

`default_nettype wire
